>>> src/csrmv_pkg.sv
// Shared types and constants for the compressed-row sparse matrix-vector block.
// Depends on nothing; every other file of the block but the vector RAM imports it.
package csrmv_pkg;

    // Number of vector elements held on chip.
    localparam int VECTOR_DEPTH = 1024;
    localparam int ADDR_W       = $clog2(VECTOR_DEPTH);

    // Field widths of the request and result items.
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 64;

    // Request operation codes.
    typedef logic [1:0] op_t;
    localparam op_t OP_LOAD  = 2'd0;
    localparam op_t OP_ACCUM = 2'd1;
    localparam op_t OP_EMIT  = 2'd2;

    // Control carried alongside the data through a pipeline stage.
    typedef struct packed {
        logic valid;
        op_t  op;
    } stage_ctl_t;

endpackage

>>> src/csr_sparse_matvec.sv
// Compressed-row sparse matrix times dense vector, Q16.16 in, Q32.32 out.
// Throughput: one request per cycle; the only stall comes when an end-of-row
// request reaches the accumulator while the previous row result is still held.
// An accepted end-of-row request passes the stage 1 and multiply registers on its way to
// the result register, which raises m_tvalid; a stall can hold it in the multiply register.
// Reset (rst_n, async, active low) clears pipeline control, accumulator and flag, not data registers or vector RAM.
module csr_sparse_matvec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [9:0] index, [41:10] value, [47:42] zero
    input  logic [1:0]  s_tuser,   // [1:0] operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] row_sum
    output logic [0:0]  m_tuser    // [0] overflow
);
    import csrmv_pkg::*;

    // Request fields unpacked from the stream payload.
    op_t                op_in;
    logic [INDEX_W-1:0] index_in;
    logic [VALUE_W-1:0] value_in;

    logic               accept;
    logic               advance;
    logic               in_range;
    logic               ram_en;
    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [VALUE_W-1:0] ram_rdata;

    // Stage 1 holds the request while the RAM delivers the element.
    stage_ctl_t         ctl_s1_reg;
    logic [VALUE_W-1:0] value_s1_reg;
    logic               in_range_s1_reg;

    logic [SUM_W-1:0]   row_sum;
    logic               overflow;

    assign op_in    = s_tuser;
    assign index_in = s_tdata[INDEX_W-1:0];
    assign value_in = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];

    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // Positions at or beyond the store depth are ignored for loads and read
    // as zero for accumulates.
    assign in_range = 32'(index_in) < 32'(VECTOR_DEPTH);
    assign ram_addr = ADDR_W'(index_in);
    assign ram_we   = (op_in == OP_LOAD);

    // A load writes and an accumulate reads; both are single-port accesses,
    // and a write lands before the next request's read, so no forwarding.
    assign ram_en = accept && in_range && (op_in == OP_LOAD || op_in == OP_ACCUM);

    csrmv_vec_ram #(
        .DEPTH (VECTOR_DEPTH),
        .WIDTH (VALUE_W)
    ) u_vec_ram (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (value_in),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s1_reg <= '0;
        end
        else if (advance)
        begin
            ctl_s1_reg.valid <= s_tvalid;
            ctl_s1_reg.op    <= op_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_s1_reg    <= value_in;
            in_range_s1_reg <= in_range;
        end
    end

    csrmv_mac u_mac (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl_s1      (ctl_s1_reg),
        .value_s1    (value_s1_reg),
        .in_range_s1 (in_range_s1_reg),
        .elem_s1     (ram_rdata),
        .out_ready   (m_tready),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .row_sum     (row_sum),
        .overflow    (overflow)
    );

    assign m_tdata    = row_sum;
    assign m_tuser[0] = overflow;

endmodule

>>> src/csrmv_vec_ram.sv
// Single-port synchronous RAM for the dense vector, with a registered read.
// Generic; depends on no package.
module csrmv_vec_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              en,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[addr] <= wdata;
        end
        if (en && !we)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/csrmv_mac.sv
// Multiply stage, saturating row accumulator and result register.
// Depends on csrmv_pkg for the operation codes and the stage control struct.
module csrmv_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  csrmv_pkg::stage_ctl_t             ctl_s1,
    input  logic [csrmv_pkg::VALUE_W-1:0]     value_s1,
    input  logic                              in_range_s1,
    input  logic [csrmv_pkg::VALUE_W-1:0]     elem_s1,
    input  logic                              out_ready,
    output logic                              advance,
    output logic                              out_valid,
    output logic [csrmv_pkg::SUM_W-1:0]       row_sum,
    output logic                              overflow
);
    import csrmv_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    stage_ctl_t          ctl_s2_reg;
    logic signed [SUM_W-1:0] prod_s2_reg;
    logic signed [SUM_W-1:0] product;
    logic [VALUE_W-1:0]  elem_sel;

    logic [SUM_W-1:0]    acc_reg, acc_next;
    logic                sat_reg, sat_next;
    logic [SUM_W-1:0]    sum_out_reg;
    logic                ovf_out_reg;
    logic                out_valid_reg, out_valid_next;

    logic [SUM_W:0]      sum_wide;
    logic                sum_ovf;
    logic                fire_accum;
    logic                fire_emit;

    // Columns beyond the store read as zero.
    assign elem_sel = in_range_s1 ? elem_s1 : '0;
    assign product  = $signed(value_s1) * $signed(elem_sel);

    // The pipeline only waits when a row result must be written over a result
    // that the consumer has not yet taken.
    assign advance = !(ctl_s2_reg.valid && ctl_s2_reg.op == OP_EMIT
                       && out_valid_reg && !out_ready);

    assign fire_accum = advance && ctl_s2_reg.valid && ctl_s2_reg.op == OP_ACCUM;
    assign fire_emit  = advance && ctl_s2_reg.valid && ctl_s2_reg.op == OP_EMIT;

    assign sum_wide = {acc_reg[SUM_W-1], acc_reg} + {prod_s2_reg[SUM_W-1], prod_s2_reg};
    assign sum_ovf  = sum_wide[SUM_W] ^ sum_wide[SUM_W-1];

    always_comb
    begin
        acc_next       = acc_reg;
        sat_next       = sat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire_accum)
        begin
            if (sum_ovf)
            begin
                acc_next = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
                sat_next = 1'b1;
            end
            else
            begin
                acc_next = sum_wide[SUM_W-1:0];
            end
        end
        else if (fire_emit)
        begin
            acc_next       = '0;
            sat_next       = 1'b0;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_s2_reg    <= '0;
            acc_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                ctl_s2_reg <= ctl_s1;
            end
            acc_reg       <= acc_next;
            sat_reg       <= sat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            prod_s2_reg <= product;
        end
        if (fire_emit)
        begin
            sum_out_reg <= acc_reg;
            ovf_out_reg <= sat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign row_sum   = sum_out_reg;
    assign overflow  = ovf_out_reg;

endmodule

>>> src/csrmv_checker.sv
// Port-level checks for csr_sparse_matvec, attached by the bind at the end.
// Depends on csrmv_pkg for the operation codes.
module csrmv_port_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [47:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import csrmv_pkg::*;

    // A held result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A held result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    // Input is refused only while a result is blocked at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // An end-of-row request that meets no stall shows its result once it has passed the multiply register.
    a_emit_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == OP_EMIT ##1 s_tready ##1 s_tready
        |=> m_tvalid)
        else $error("row result missing after end-of-row request");

endmodule

bind csr_sparse_matvec csrmv_port_checks u_csrmv_checker (.*);

>>> tb/csrmv_checker.sv
`timescale 1ns / 1ps
// Result checker for the sparse matrix-vector block: watches both stream channels,
// predicts each row sum from the accepted requests and compares it with the output.
// Depends on csrmv_pkg for widths and operation codes.
module csrmv_checker
    import csrmv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [0:0]  m_tuser,
    output int          fail_count,
    output int          pending_rows,
    output int          rows_checked,
    output int          saturated_rows
);

    typedef struct packed {
        logic [SUM_W-1:0] row_sum;
        logic             overflow;
    } row_result_t;

    localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    row_result_t        expected_rows[$];
    logic [VALUE_W-1:0] vector_copy [VECTOR_DEPTH];
    logic [SUM_W-1:0]   running_sum;
    logic               running_sat;

    initial
    begin
        fail_count     = 0;
        pending_rows   = 0;
        rows_checked   = 0;
        saturated_rows = 0;
    end

    // Adds one matrix entry times its vector element to the running row sum,
    // clamping at the signed 64-bit limits and latching the saturation flag.
    function automatic void add_product_clamped(input logic [VALUE_W-1:0] entry,
                                                input logic [VALUE_W-1:0] element);
        logic signed [VALUE_W-1:0] a;
        logic signed [VALUE_W-1:0] b;
        logic signed [SUM_W-1:0]   product;
        logic [SUM_W-1:0]          total;
        a       = entry;
        b       = element;
        product = a * b;
        total   = running_sum + product;
        if (running_sum[SUM_W-1] == product[SUM_W-1] && total[SUM_W-1] != running_sum[SUM_W-1])
        begin
            total       = running_sum[SUM_W-1] ? SUM_MIN : SUM_MAX;
            running_sat = 1'b1;
        end
        running_sum = total;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        row_result_t              want;
        logic [INDEX_W-1:0]       idx;
        logic [VALUE_W-1:0]       val;
        if (!rst_n)
        begin
            running_sum = '0;
            running_sat = 1'b0;
            expected_rows.delete();
            pending_rows <= 0;
        end
        else
        begin
            // A result accepted now cannot stem from a request accepted at the same
            // edge, so results are checked before the request is folded in.
            if (m_tvalid && m_tready)
            begin
                if (expected_rows.size() == 0)
                begin
                    $display("%0t: unexpected row result %h overflow %b", $time,
                             m_tdata, m_tuser[0]);
                    fail_count++;
                end
                else
                begin
                    want = expected_rows.pop_front();
                    if (m_tdata !== want.row_sum)
                    begin
                        $display("%0t: row %0d row_sum expected %h actual %h", $time,
                                 rows_checked, want.row_sum, m_tdata);
                        fail_count++;
                    end
                    if (m_tuser[0] !== want.overflow)
                    begin
                        $display("%0t: row %0d overflow expected %b actual %b", $time,
                                 rows_checked, want.overflow, m_tuser[0]);
                        fail_count++;
                    end
                    if (want.overflow)
                        saturated_rows++;
                    rows_checked++;
                end
            end

            if (s_tvalid && s_tready)
            begin
                idx = s_tdata[INDEX_W-1:0];
                val = s_tdata[INDEX_W+VALUE_W-1:INDEX_W];
                case (s_tuser)
                    OP_LOAD:
                        vector_copy[idx] = val;
                    OP_ACCUM:
                        add_product_clamped(val, vector_copy[idx]);
                    OP_EMIT:
                    begin
                        expected_rows.push_back('{row_sum: running_sum, overflow: running_sat});
                        running_sum = '0;
                        running_sat = 1'b0;
                    end
                    default:
                        ;
                endcase
            end
            pending_rows <= expected_rows.size();
        end
    end

endmodule

>>> tb/tb_csr_sparse_matvec.sv
`timescale 1ns / 1ps
// Top of the sparse matrix-vector testbench: clock, reset, request stimulus and verdict.
// Depends on csrmv_pkg, the csr_sparse_matvec block and the csrmv_checker module.
module tb_csr_sparse_matvec;
    import csrmv_pkg::*;

    // Operation code the block must ignore.
    localparam op_t OP_UNUSED     = 2'd3;
    localparam int  QUIET_LIMIT   = 2000;
    localparam int  DRAIN_CYCLES  = 8;
    localparam int  PAD_W         = 48 - INDEX_W - VALUE_W;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;

    int fail_count;
    int pending_rows;
    int rows_checked;
    int saturated_rows;

    // Pressure knobs, percent of cycles.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    int requests_sent = 0;
    int loads_sent    = 0;
    int entries_sent  = 0;
    int rows_sent     = 0;
    int quiet_cycles  = 0;

    // Vector positions loaded since reset; accumulates only ever read these.
    int written_idx[$];
    bit written_map [VECTOR_DEPTH];

    csr_sparse_matvec dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    csrmv_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending_rows   (pending_rows),
        .rows_checked   (rows_checked),
        .saturated_rows (saturated_rows)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side back-pressure.
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Presents one request and returns at the edge that accepts it. Handshake
    // inputs only move at rising edges, so the negative edge shows what the
    // next rising edge will see.
    task automatic send_request(input op_t op, input logic [INDEX_W-1:0] idx,
                                input logic [VALUE_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{PAD_W{1'b0}}, val, idx};
        do
            @(negedge clk);
        while (!s_tready);
        @(posedge clk);
        case (op)
            OP_LOAD:  loads_sent++;
            OP_ACCUM: entries_sent++;
            OP_EMIT:  rows_sent++;
            default:  ;
        endcase
        if (op != OP_UNUSED)
            requests_sent++;
    endtask

    task automatic load_element(input logic [INDEX_W-1:0] idx, input logic [VALUE_W-1:0] val);
        send_request(OP_LOAD, idx, val);
        if (!written_map[idx])
        begin
            written_map[idx] = 1'b1;
            written_idx.push_back(int'(idx));
        end
    endtask

    // Mix of extremes, full-range and small Q16.16 values.
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [19:0] frac;
        frac = 20'($urandom);
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2, 3, 4: return $urandom;
            default: return {{12{frac[19]}}, frac};
        endcase
    endfunction

    // Random rows: occasional bursts of vector loads, ordinary rows of random
    // entries with stray unused codes, and heavy rows of extreme products that
    // push the sum into saturation and sometimes back out.
    task automatic run_random_phase(input int count);
        int stop_at;
        int len;
        int n;
        logic [INDEX_W-1:0] hot;
        logic [VALUE_W-1:0] major;
        logic [VALUE_W-1:0] minor;
        stop_at = requests_sent + count;
        while (requests_sent < stop_at)
        begin
            if ($urandom_range(9) == 0)
            begin
                n = $urandom_range(1, 8);
                repeat (n)
                    load_element(INDEX_W'($urandom_range(VECTOR_DEPTH - 1)), pick_value());
            end
            if ($urandom_range(7) == 0)
            begin
                hot = INDEX_W'($urandom_range(VECTOR_DEPTH - 1));
                load_element(hot, $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
                major = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                minor = ~major;
                len = $urandom_range(2, 8);
                repeat (len)
                    send_request(OP_ACCUM, hot, ($urandom_range(3) == 0) ? minor : major);
            end
            else
            begin
                len = $urandom_range(0, 10);
                repeat (len)
                begin
                    if ($urandom_range(19) == 0)
                        send_request(OP_UNUSED, INDEX_W'($urandom), $urandom);
                    send_request(OP_ACCUM,
                                 INDEX_W'(written_idx[$urandom_range(written_idx.size() - 1)]),
                                 pick_value());
                end
            end
            send_request(OP_EMIT, INDEX_W'($urandom), $urandom);
        end
    endtask

    // A run that stops accepting anything for too long is a hang.
    initial
    begin
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(negedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no request or result accepted for %0d cycles", $time, QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling. Elements at both ends of the store hold the
        // most negative and most positive values; two more hold plus and minus one.
        load_element(10'd0, 32'h8000_0000);
        load_element(INDEX_W'(VECTOR_DEPTH - 1), 32'h7FFF_FFFF);
        load_element(10'd341, 32'h0001_0000);
        load_element(10'd682, 32'hFFFF_0000);
        // Empty rows, back to back, with junk in the ignored fields.
        send_request(OP_EMIT, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_EMIT, 10'h000, 32'h0000_0000);
        // Plain row with an unused code in the middle that must change nothing.
        send_request(OP_ACCUM, 10'd341, 32'h0001_8000);
        send_request(OP_ACCUM, 10'd682, 32'h7FFF_FFFF);
        send_request(OP_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
        send_request(OP_EMIT, 10'h155, 32'h5555_5555);
        // Three products of 2^62 overflow upward; a negative one then pulls the
        // clamped sum back inside the range while the flag stays set.
        repeat (3)
            send_request(OP_ACCUM, 10'd0, 32'h8000_0000);
        send_request(OP_ACCUM, 10'd0, 32'h7FFF_FFFF);
        send_request(OP_EMIT, 10'h2AA, 32'hAAAA_AAAA);
        // Third large negative product overflows downward.
        repeat (3)
            send_request(OP_ACCUM, INDEX_W'(VECTOR_DEPTH - 1), 32'h8000_0000);
        send_request(OP_EMIT, 10'h000, 32'h0000_0000);
        // Read right after a write to the same element.
        load_element(10'd341, 32'h0002_0000);
        send_request(OP_ACCUM, 10'd341, 32'h0001_0000);
        send_request(OP_EMIT, 10'h000, 32'h0000_0000);

        run_random_phase(240);
        send_idle_pct  = 63;
        recv_stall_pct = 0;
        run_random_phase(240);
        send_idle_pct  = 0;
        recv_stall_pct = 63;
        run_random_phase(240);
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        run_random_phase(230);
        s_tvalid <= 1'b0;

        do
            @(negedge clk);
        while (pending_rows != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests: %0d vector loads, %0d matrix entries, %0d rows.",
                 requests_sent, loads_sent, entries_sent, rows_sent);
        $display("Checked %0d row sums, %0d of them saturated, under four pressure mixes.",
                 rows_checked, saturated_rows);
        if (fail_count == 0 && pending_rows == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
